### sv/assert_macros.svh
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define NGGA_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("ngga port assertion failed");

// condition in one cycle implies a consequence in the next cycle
`define NGGA_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
		else $error("ngga port assertion failed");

`endif

### sv/ngga_pkg.sv
// types, constants and helper functions of the gga sentence parser
package ngga_pkg;

	localparam int unsigned FRACTION_DIGITS_DEF = 5;
	localparam int unsigned MINS_W = 30;
	localparam int unsigned OUT_TDATA_W = 88;
	localparam logic [23:0] E7_SCALE = 24'd10000000;
	localparam logic [28:0] RECIP_15 = 29'd286331154;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_SOUTH = 8'h53;
	localparam logic [7:0] CH_WEST = 8'h57;

	localparam logic [2:0] PM_START = 3'd1;
	localparam logic [2:0] PM_DONE = 3'd6;
	localparam logic [2:0] PM_FAIL = 3'd7;

	localparam logic [3:0] FLD_TIME = 4'd1;
	localparam logic [3:0] FLD_LAT = 4'd2;
	localparam logic [3:0] FLD_NS = 4'd3;
	localparam logic [3:0] FLD_LON = 4'd4;
	localparam logic [3:0] FLD_EW = 4'd5;
	localparam logic [3:0] FLD_MAX = 4'd15;

	typedef logic [MINS_W-1:0] mins_t;

	typedef struct packed {
		logic       is_gga;
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [6:0] lat_deg;
		mins_t      lat_mins;
		logic       lat_neg;
		logic [9:0] lon_deg;
		mins_t      lon_mins;
		logic       lon_neg;
	} snap_t;

	function automatic logic [23:0] pow10(input logic [2:0] n);
		logic [23:0] r;
		case (n)
			3'd0: r = 24'd1;
			3'd1: r = 24'd10;
			3'd2: r = 24'd100;
			3'd3: r = 24'd1000;
			3'd4: r = 24'd10000;
			3'd5: r = 24'd100000;
			3'd6: r = 24'd1000000;
			default: r = 24'd10000000;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd1: r = 8'h47;
			3'd2: r = 8'h50;
			3'd3: r = 8'h47;
			3'd4: r = 8'h47;
			3'd5: r = 8'h41;
			default: r = CH_DOLLAR;
		endcase
		return r;
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
	endfunction

endpackage

### sv/ngga_parser.sv
// per-character sentence parser with snapshot register of a finished sentence
module ngga_parser #(
	parameter int unsigned FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_byte,
	output logic              snap_valid,
	input  logic              snap_ready,
	output ngga_pkg::snap_t   snap
);

	localparam logic [23:0] UNIT = ngga_pkg::pow10(3'(FRACTION_DIGITS));
	localparam int unsigned MIN_W = $clog2(100 * int'(UNIT));
	localparam int unsigned EXT_W = MIN_W + 4;
	localparam logic [EXT_W-1:0] CAP = EXT_W'(99 * int'(UNIT));

	logic             in_sentence_q, in_sentence_d;
	logic [2:0]       pm_q, pm_d;
	logic             prefix_ok_q, prefix_ok_d;
	logic [3:0]       field_q, field_d;
	logic [3:0]       pos_q, pos_d;
	logic [6:0]       hour_q, hour_d;
	logic [6:0]       minute_q, minute_d;
	logic [6:0]       second_q, second_d;
	logic [6:0]       lat_deg_q, lat_deg_d;
	logic [MIN_W-1:0] lat_min_q, lat_min_d;
	logic             lat_s_q, lat_s_d;
	logic [9:0]       lon_deg_q, lon_deg_d;
	logic [MIN_W-1:0] lon_min_q, lon_min_d;
	logic             lon_w_q, lon_w_d;
	logic             after_pt_q, after_pt_d;
	logic [2:0]       frac_q, frac_d;

	logic             snap_valid_s1;
	ngga_pkg::snap_t  snap_s1;

	logic             accept;
	logic             emit;
	logic             digit;
	logic [3:0]       d;
	logic [MIN_W-1:0] sel_min;
	logic [EXT_W-1:0] int_step;
	logic [MIN_W-1:0] frac_add;
	logic [MIN_W-1:0] min_new;
	logic             after_pt_new;
	logic [2:0]       frac_new;
	logic             deg_pos;

	assign in_ready = !snap_valid_s1 || snap_ready;
	assign accept = in_valid && in_ready;
	assign snap_valid = snap_valid_s1;
	assign snap = snap_s1;

	assign digit = in_byte inside {[8'h30:8'h39]};
	assign d = digit ? in_byte[3:0] : 4'd0;

	// minutes digit handling shared by the latitude and longitude fields
	assign sel_min = (field_q == ngga_pkg::FLD_LON) ? lon_min_q : lat_min_q;
	assign int_step = EXT_W'(sel_min) * EXT_W'(10) + EXT_W'(d) * EXT_W'(UNIT);
	assign frac_add = MIN_W'(d) *
		MIN_W'(ngga_pkg::pow10(3'(FRACTION_DIGITS - 1) - frac_q));
	assign deg_pos = (field_q == ngga_pkg::FLD_LON) ? (pos_q < 4'd3) : (pos_q < 4'd2);

	always_comb begin
		min_new = sel_min;
		after_pt_new = after_pt_q;
		frac_new = frac_q;
		if (!after_pt_q) begin
			if (in_byte == ngga_pkg::CH_POINT) begin
				after_pt_new = 1'b1;
			end else if (digit) begin
				min_new = (int_step > CAP) ? MIN_W'(CAP) : MIN_W'(int_step);
			end
		end else if (digit && frac_q < 3'(FRACTION_DIGITS)) begin
			min_new = sel_min + frac_add;
			frac_new = frac_q + 3'd1;
		end
	end

	always_comb begin
		in_sentence_d = in_sentence_q;
		pm_d = pm_q;
		prefix_ok_d = prefix_ok_q;
		field_d = field_q;
		pos_d = pos_q;
		hour_d = hour_q;
		minute_d = minute_q;
		second_d = second_q;
		lat_deg_d = lat_deg_q;
		lat_min_d = lat_min_q;
		lat_s_d = lat_s_q;
		lon_deg_d = lon_deg_q;
		lon_min_d = lon_min_q;
		lon_w_d = lon_w_q;
		after_pt_d = after_pt_q;
		frac_d = frac_q;
		emit = 1'b0;
		if (accept && (in_byte == ngga_pkg::CH_DOLLAR || (in_sentence_q &&
				ngga_pkg::is_ws(in_byte)))) begin
			// sentence start or end clears all sentence state
			pm_d = '0;
			prefix_ok_d = 1'b0;
			field_d = '0;
			pos_d = '0;
			hour_d = '0;
			minute_d = '0;
			second_d = '0;
			lat_deg_d = '0;
			lat_min_d = '0;
			lat_s_d = 1'b0;
			lon_deg_d = '0;
			lon_min_d = '0;
			lon_w_d = 1'b0;
			after_pt_d = 1'b0;
			frac_d = '0;
			if (in_byte == ngga_pkg::CH_DOLLAR) begin
				in_sentence_d = 1'b1;
				pm_d = ngga_pkg::PM_START;
			end else begin
				in_sentence_d = 1'b0;
				emit = 1'b1;
			end
		end else if (accept && in_sentence_q) begin
			if (pm_q != 3'd0 && pm_q < ngga_pkg::PM_DONE) begin
				if (in_byte == ngga_pkg::prefix_char(pm_q)) begin
					pm_d = pm_q + 3'd1;
					if (pm_q == ngga_pkg::PM_DONE - 3'd1) begin
						prefix_ok_d = 1'b1;
					end
				end else begin
					pm_d = ngga_pkg::PM_FAIL;
				end
			end
			if (in_byte == ngga_pkg::CH_COMMA) begin
				if (field_q != ngga_pkg::FLD_MAX) begin
					field_d = field_q + 4'd1;
				end
				pos_d = '0;
				after_pt_d = 1'b0;
				frac_d = '0;
			end else begin
				case (field_q)
					ngga_pkg::FLD_TIME: begin
						if (digit && pos_q < 4'd2) begin
							hour_d = hour_q * 7'd10 + 7'(d);
						end else if (digit && pos_q < 4'd4) begin
							minute_d = minute_q * 7'd10 + 7'(d);
						end else if (digit && pos_q < 4'd6) begin
							second_d = second_q * 7'd10 + 7'(d);
						end
					end
					ngga_pkg::FLD_LAT: begin
						if (deg_pos) begin
							if (digit) begin
								lat_deg_d = lat_deg_q * 7'd10 + 7'(d);
							end
						end else begin
							lat_min_d = min_new;
							after_pt_d = after_pt_new;
							frac_d = frac_new;
						end
					end
					ngga_pkg::FLD_NS: begin
						if (pos_q == 4'd0 && in_byte == ngga_pkg::CH_SOUTH) begin
							lat_s_d = 1'b1;
						end
					end
					ngga_pkg::FLD_LON: begin
						if (deg_pos) begin
							if (digit) begin
								lon_deg_d = lon_deg_q * 10'd10 + 10'(d);
							end
						end else begin
							lon_min_d = min_new;
							after_pt_d = after_pt_new;
							frac_d = frac_new;
						end
					end
					ngga_pkg::FLD_EW: begin
						if (pos_q == 4'd0 && in_byte == ngga_pkg::CH_WEST) begin
							lon_w_d = 1'b1;
						end
					end
					default: begin
					end
				endcase
				if (pos_q != 4'd15) begin
					pos_d = pos_q + 4'd1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_sentence_q <= 1'b0;
			pm_q <= '0;
			prefix_ok_q <= 1'b0;
			field_q <= '0;
			pos_q <= '0;
			hour_q <= '0;
			minute_q <= '0;
			second_q <= '0;
			lat_deg_q <= '0;
			lat_min_q <= '0;
			lat_s_q <= 1'b0;
			lon_deg_q <= '0;
			lon_min_q <= '0;
			lon_w_q <= 1'b0;
			after_pt_q <= 1'b0;
			frac_q <= '0;
			snap_valid_s1 <= 1'b0;
		end else begin
			in_sentence_q <= in_sentence_d;
			pm_q <= pm_d;
			prefix_ok_q <= prefix_ok_d;
			field_q <= field_d;
			pos_q <= pos_d;
			hour_q <= hour_d;
			minute_q <= minute_d;
			second_q <= second_d;
			lat_deg_q <= lat_deg_d;
			lat_min_q <= lat_min_d;
			lat_s_q <= lat_s_d;
			lon_deg_q <= lon_deg_d;
			lon_min_q <= lon_min_d;
			lon_w_q <= lon_w_d;
			after_pt_q <= after_pt_d;
			frac_q <= frac_d;
			if (emit) begin
				snap_valid_s1 <= 1'b1;
			end else if (snap_ready) begin
				snap_valid_s1 <= 1'b0;
			end
		end
	end

	// non-gga sentences report all zero
	always_ff @(posedge clk) begin
		if (emit) begin
			snap_s1.is_gga <= prefix_ok_q;
			snap_s1.hour <= prefix_ok_q ? hour_q : 7'd0;
			snap_s1.minute <= prefix_ok_q ? minute_q : 7'd0;
			snap_s1.second <= prefix_ok_q ? second_q : 7'd0;
			snap_s1.lat_deg <= prefix_ok_q ? lat_deg_q : 7'd0;
			snap_s1.lat_mins <= prefix_ok_q ? ngga_pkg::mins_t'(lat_min_q) : '0;
			snap_s1.lat_neg <= prefix_ok_q && lat_s_q;
			snap_s1.lon_deg <= prefix_ok_q ? lon_deg_q : 10'd0;
			snap_s1.lon_mins <= prefix_ok_q ? ngga_pkg::mins_t'(lon_min_q) : '0;
			snap_s1.lon_neg <= prefix_ok_q && lon_w_q;
		end
	end

endmodule

### sv/ngga_convert.sv
// pipeline turning degrees and scaled minutes into signed 1e-7 degree units
module ngga_convert #(
	parameter int unsigned FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ngga_pkg::snap_t                   snap,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              out_gga,
	output logic [ngga_pkg::OUT_TDATA_W-1:0]  out_data
);

	localparam int unsigned X_W = ngga_pkg::MINS_W;
	localparam logic [23:0] SCALE = ngga_pkg::pow10(3'(7 - FRACTION_DIGITS));

	logic        v_s2, v_s3, out_v_q;
	logic        rdy_s2, rdy_s3, rdy_o;

	logic        gga_s2, gga_s3;
	logic [20:0] hms_s2, hms_s3;
	logic        lat_neg_s2, lat_neg_s3, lon_neg_s2, lon_neg_s3;
	logic [34:0] lat_e7_s2, lat_e7_s3, lon_e7_s2, lon_e7_s3;
	logic [X_W-1:0] lat_x_s2, lon_x_s2;
	logic [24:0] lat_q_s3, lon_q_s3;

	logic [56:0] lat_p, lon_p;
	logic [34:0] lat_mag, lon_mag, lat_val, lon_val;

	logic        gga_q;
	logic [ngga_pkg::OUT_TDATA_W-1:0] data_q;

	assign rdy_o = !out_v_q || out_ready;
	assign rdy_s3 = !v_s3 || rdy_o;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign in_ready = rdy_s2;

	// floor(x / 60) as floor((x >> 2) / 15) by reciprocal
	assign lat_p = 57'(lat_x_s2[X_W-1:2]) * 57'(ngga_pkg::RECIP_15);
	assign lon_p = 57'(lon_x_s2[X_W-1:2]) * 57'(ngga_pkg::RECIP_15);

	assign lat_mag = lat_e7_s3 + 35'(lat_q_s3);
	assign lon_mag = lon_e7_s3 + 35'(lon_q_s3);
	assign lat_val = lat_neg_s3 ? 35'd0 - lat_mag : lat_mag;
	assign lon_val = lon_neg_s3 ? 35'd0 - lon_mag : lon_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s2) begin
				v_s2 <= in_valid;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_o) begin
				out_v_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && in_valid) begin
			gga_s2 <= snap.is_gga;
			hms_s2 <= {snap.second, snap.minute, snap.hour};
			lat_neg_s2 <= snap.lat_neg;
			lon_neg_s2 <= snap.lon_neg;
			lat_e7_s2 <= 35'(snap.lat_deg) * 35'(ngga_pkg::E7_SCALE);
			lon_e7_s2 <= 35'(snap.lon_deg) * 35'(ngga_pkg::E7_SCALE);
			lat_x_s2 <= X_W'(snap.lat_mins) * X_W'(SCALE);
			lon_x_s2 <= X_W'(snap.lon_mins) * X_W'(SCALE);
		end
		if (rdy_s3 && v_s2) begin
			gga_s3 <= gga_s2;
			hms_s3 <= hms_s2;
			lat_neg_s3 <= lat_neg_s2;
			lon_neg_s3 <= lon_neg_s2;
			lat_e7_s3 <= lat_e7_s2;
			lon_e7_s3 <= lon_e7_s2;
			lat_q_s3 <= lat_p[56:32];
			lon_q_s3 <= lon_p[56:32];
		end
		if (rdy_o && v_s3) begin
			gga_q <= gga_s3;
			data_q <= {1'b0, lon_val, lat_val[30:0], hms_s3};
		end
	end

	assign out_valid = out_v_q;
	assign out_gga = gga_q;
	assign out_data = data_q;

endmodule

### sv/nmea_gga_position_parser.sv
// top level of the nmea gga position parser
// Takes one NMEA character per cycle on s_axis and never stalls the stream
// unless the four result slots (snapshot, two conversion stages and the output
// register) are all full. A '$' starts a sentence and a whitespace byte ends
// it; the end of each sentence produces one result on m_axis: the snapshot
// register loads on the edge that accepts the whitespace byte, then the minutes
// scaling multiply, the divide-by-60 reciprocal multiply and the output
// register follow as registered stages in turn. tuser is 1 for a $GPGGA sentence; any
// other sentence returns zeros. Position comes out as signed 1e-7 degree units,
// minutes kept to FRACTION_DIGITS decimal places.
module nmea_gga_position_parser #(
	parameter int unsigned FRACTION_DIGITS = ngga_pkg::FRACTION_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [7:0]                        s_axis_tdata,   // rx_byte
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// utc_hour, utc_minute, utc_second, latitude_e7, longitude_e7, zero pad
	output logic [ngga_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	output logic                              m_axis_tuser    // is_gga
);

	logic            snap_valid;
	logic            snap_ready;
	ngga_pkg::snap_t snap;

	ngga_parser #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_byte   (s_axis_tdata),
		.snap_valid(snap_valid),
		.snap_ready(snap_ready),
		.snap      (snap)
	);

	ngga_convert #(
		.FRACTION_DIGITS(FRACTION_DIGITS)
	) u_convert (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (snap_valid),
		.in_ready (snap_ready),
		.snap     (snap),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_gga  (m_axis_tuser),
		.out_data (m_axis_tdata)
	);

endmodule

### sv/ngga_checker.sv
// port checker of the gga parser and its bind to the top level
`include "assert_macros.svh"

module ngga_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              s_axis_tvalid,
	input logic                              s_axis_tready,
	input logic [7:0]                        s_axis_tdata,
	input logic                              m_axis_tvalid,
	input logic                              m_axis_tready,
	input logic [ngga_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
	input logic                              m_axis_tuser
);

	logic in_req;

	// accepted input byte other than zero, used as the trigger of the ready assertion
	assign in_req = s_axis_tvalid && s_axis_tready && s_axis_tdata != 8'h00;

	`NGGA_ASSERT_NEXT(a_out_valid_held, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`NGGA_ASSERT_NEXT(a_out_data_held, clk, arst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser))
	`NGGA_ASSERT(a_non_gga_zero, clk, arst_n, m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
	`NGGA_ASSERT(a_time_range, clk, arst_n, m_axis_tvalid |-> m_axis_tdata[6:0] <= 7'd99 && m_axis_tdata[13:7] <= 7'd99 && m_axis_tdata[20:14] <= 7'd99 && !m_axis_tdata[87])
	`NGGA_ASSERT_NEXT(a_ready_after_req, clk, arst_n, in_req && !m_axis_tvalid, s_axis_tready)

endmodule

bind nmea_gga_position_parser ngga_checker u_ngga_checker (.*);
